@@ design/lav_pkg.sv @@
// shared types and constants for the look-at view matrix core
// no dependencies; imported by lav_norm and look_at_view_matrix_core
`default_nettype none

package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int AXIS_W        = 18;
  localparam int ROW_BITS      = 2;
  localparam int MAG_W         = 64;

  localparam logic [WORD_W-1:0] TR_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] TR_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic [ROW_BITS-1:0] {
    ROW_U = 2'd0,
    ROW_V = 2'd1,
    ROW_W = 2'd2
  } row_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } norm_stat_t;

endpackage

`default_nettype wire

@@ design/lav_norm.sv @@
// pipelined vector normalizer: max search, leading-one shift, squares,
// radix-4 square root and restoring division, sideband carried alongside
// depends on lav_pkg
`default_nettype none

module lav_norm #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  lav_pkg::mag_t [2:0]           in_mag,
  input  logic [2:0]                    in_neg,
  input  logic [SIDE_W-1:0]             in_side,
  output lav_pkg::norm_stat_t           out_stat,
  output logic [2:0][FRAC_BITS+1:0]     out_q,
  output logic [SIDE_W-1:0]             out_side
);
  import lav_pkg::*;

  localparam int AW      = FRAC_BITS + 2;
  localparam int QW      = FRAC_BITS + 1;
  localparam int NW      = FRAC_BITS + 32;
  localparam int M_W     = 31;
  localparam int TOP_BIT = M_W - 1;
  localparam int LEN_W   = MAG_W / 2;
  localparam int LZ_W    = $clog2(MAG_W);
  localparam int SQ_STG  = LEN_W / 2;
  localparam int DIV_STG = (QW + 1) / 2;
  localparam int VLD_N   = 4 + (SQ_STG + 1) + (DIV_STG + 1) + 1;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [2:0]        neg;
    logic              zero;
    logic [SIDE_W-1:0] side;
  } tag_t;

  typedef logic [M_W-1:0] m_t;

  logic [VLD_N-1:0] vld_r;

  // max search
  mag_t              mag0_r [3];
  logic [2:0]        neg0_r;
  logic [SIDE_W-1:0] side0_r;
  mag_t              mx0_r;
  mag_t              mx0_nxt;

  // leading one
  mag_t              mag1_r [3];
  logic [2:0]        neg1_r;
  logic [SIDE_W-1:0] side1_r;
  logic [LZ_W-1:0]   lead1_r;
  logic              zero1_r;
  logic [LZ_W-1:0]   lead1_nxt;

  // shifted magnitudes and squares
  m_t                m2_r [3];
  tag_t              tag2_r;
  m_t                m2_nxt [3];
  logic [2*M_W-1:0]  sq3_r [3];
  m_t                m3_r [3];
  tag_t              tag3_r;

  // square root chain
  mag_t              sx_r   [SQ_STG+1];
  mag_t              sres_r [SQ_STG+1];
  m_t                sm_r   [SQ_STG+1][3];
  tag_t              stag_r [SQ_STG+1];
  mag_t              sx_nxt   [SQ_STG];
  mag_t              sres_nxt [SQ_STG];

  // division chain
  logic [NW-1:0]     drem_r [DIV_STG+1][3];
  logic [QW-1:0]     dq_r   [DIV_STG+1][3];
  logic [LEN_W-1:0]  dden_r [DIV_STG+1];
  tag_t              dtag_r [DIV_STG+1];
  logic [NW-1:0]     drem_nxt [DIV_STG][3];
  logic [QW-1:0]     dq_nxt   [DIV_STG][3];
  logic [LEN_W-1:0]  len_w;

  logic [AW-1:0]     q_r [3];
  tag_t              tagf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLD_N-2:0], in_valid};
    end
  end

  always_comb begin
    mx0_nxt = in_mag[0];
    if (in_mag[1] > mx0_nxt) mx0_nxt = in_mag[1];
    if (in_mag[2] > mx0_nxt) mx0_nxt = in_mag[2];
  end

  always_comb begin
    lead1_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx0_r[i]) lead1_nxt = LZ_W'(i);
    end
  end

  always_comb begin
    mag_t t;
    for (int i = 0; i < 3; i++) begin
      if (lead1_r >= LZ_W'(TOP_BIT)) t = mag1_r[i] >> (lead1_r - LZ_W'(TOP_BIT));
      else                           t = mag1_r[i] << (LZ_W'(TOP_BIT) - lead1_r);
      m2_nxt[i] = t[M_W-1:0];
    end
  end

  // two root digits per stage
  always_comb begin
    mag_t x;
    mag_t r;
    mag_t b;
    mag_t t;
    for (int s = 0; s < SQ_STG; s++) begin
      x = sx_r[s];
      r = sres_r[s];
      for (int j = 0; j < 2; j++) begin
        b = MAG_W'(1) << (MAG_W - 2 - 2 * (2 * s + j));
        t = r + b;
        if (x >= t) begin
          x = x - t;
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      sx_nxt[s]   = x;
      sres_nxt[s] = r;
    end
  end

  assign len_w = sres_r[SQ_STG][LEN_W-1:0];

  // two quotient bits per stage
  always_comb begin
    logic [NW-1:0] rem;
    logic [NW-1:0] dsh;
    logic [QW-1:0] q;
    int            b;
    for (int s = 0; s < DIV_STG; s++) begin
      for (int i = 0; i < 3; i++) begin
        rem = drem_r[s][i];
        q   = dq_r[s][i];
        for (int j = 0; j < 2; j++) begin
          b = QW - 1 - (2 * s + j);
          if (b >= 0) begin
            dsh = NW'(dden_r[s]) << b;
            if (rem >= dsh) begin
              rem  = rem - dsh;
              q[b] = 1'b1;
            end
          end
        end
        drem_nxt[s][i] = rem;
        dq_nxt[s][i]   = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0] qc;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag0_r[i] <= in_mag[i];
        mag1_r[i] <= mag0_r[i];
        m2_r[i]   <= m2_nxt[i];
        sq3_r[i]  <= m2_r[i] * m2_r[i];
        m3_r[i]   <= m2_r[i];
      end
      neg0_r  <= in_neg;
      side0_r <= in_side;
      mx0_r   <= mx0_nxt;

      neg1_r  <= neg0_r;
      side1_r <= side0_r;
      lead1_r <= lead1_nxt;
      zero1_r <= (mx0_r == '0);

      tag2_r  <= '{neg: neg1_r, zero: zero1_r, side: side1_r};
      tag3_r  <= tag2_r;

      sx_r[0]   <= MAG_W'(sq3_r[0]) + MAG_W'(sq3_r[1]) + MAG_W'(sq3_r[2]);
      sres_r[0] <= '0;
      sm_r[0]   <= m3_r;
      stag_r[0] <= tag3_r;
      for (int s = 0; s < SQ_STG; s++) begin
        sx_r[s+1]   <= sx_nxt[s];
        sres_r[s+1] <= sres_nxt[s];
        sm_r[s+1]   <= sm_r[s];
        stag_r[s+1] <= stag_r[s];
      end

      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= (NW'(sm_r[SQ_STG][i]) << FRAC_BITS) + NW'(len_w >> 1);
        dq_r[0][i]   <= '0;
      end
      dden_r[0] <= len_w;
      dtag_r[0] <= stag_r[SQ_STG];
      for (int s = 0; s < DIV_STG; s++) begin
        drem_r[s+1] <= drem_nxt[s];
        dq_r[s+1]   <= dq_nxt[s];
        dden_r[s+1] <= dden_r[s];
        dtag_r[s+1] <= dtag_r[s];
      end

      for (int i = 0; i < 3; i++) begin
        qc = (dq_r[DIV_STG][i] > Q_ONE) ? Q_ONE : dq_r[DIV_STG][i];
        q_r[i] <= dtag_r[DIV_STG].neg[i] ? (AW'(0) - AW'(qc)) : AW'(qc);
      end
      tagf_r <= dtag_r[DIV_STG];
    end
  end

  assign out_stat.valid = vld_r[VLD_N-1];
  assign out_stat.zero  = tagf_r.zero;
  assign out_side       = tagf_r.side;
  always_comb begin
    for (int i = 0; i < 3; i++) out_q[i] = q_r[i];
  end

endmodule

`default_nettype wire

@@ design/look_at_view_matrix_core.sv @@
// look-at view matrix core: each input item gives three rows, one per cycle
// while out_ready is high, on the single result port, so a new item is taken
// only once the held item's last row is taken or no item is held. the
// pipeline stalls as a whole while rows wait.
// synchronous active-low reset clears all valid bits and the row counter.
// depends on lav_pkg and lav_norm
`default_nettype none

module look_at_view_matrix_core #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_pos_x,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_pos_y,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_pos_z,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_dir_x,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_dir_y,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_dir_z,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_up_x,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_up_y,
  input  logic signed [lav_pkg::WORD_W-1:0]  in_up_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lav_pkg::ROW_BITS-1:0]       out_row_index,
  output logic signed [lav_pkg::AXIS_W-1:0]  out_axis_x,
  output logic signed [lav_pkg::AXIS_W-1:0]  out_axis_y,
  output logic signed [lav_pkg::AXIS_W-1:0]  out_axis_z,
  output logic signed [lav_pkg::WORD_W-1:0]  out_translation,
  output logic                               out_degenerate,
  output logic                               out_last_row
);
  import lav_pkg::*;

  localparam int AW   = FRAC_BITS + 2;
  localparam int VP_W = 2 * AW;
  localparam int VT_W = VP_W + 1;
  localparam int TP_W = AW + WORD_W;
  localparam int SS_W = TP_W + 2;
  localparam int T_N  = 6;
  localparam logic [VT_W-1:0] V_HALF = VT_W'(1) << (FRAC_BITS - 1);
  localparam logic [VT_W-1:0] V_ONE  = VT_W'(1) << FRAC_BITS;
  localparam logic [SS_W-1:0] S_HALF = SS_W'(1) << (FRAC_BITS - 1);
  localparam logic [SS_W-1:0] S_MAXP = SS_W'(TR_MAX);
  localparam logic [SS_W-1:0] S_MAXN = SS_W'(1) << (WORD_W - 1);

  function automatic logic [AW-1:0] round_axis(input logic [VT_W-1:0] t);
    logic            neg;
    logic [VT_W-1:0] m;
    logic [VT_W-1:0] r;
    neg = t[VT_W-1];
    m   = neg ? (VT_W'(0) - t) : t;
    r   = (m + V_HALF) >> FRAC_BITS;
    if (r > V_ONE) r = V_ONE;
    return neg ? AW'(VT_W'(0) - r) : AW'(r);
  endfunction

  // minus the rounded sum, saturated
  function automatic logic [WORD_W-1:0] sat_tr(input logic [SS_W-1:0] s);
    logic            neg;
    logic [SS_W-1:0] m;
    logic [SS_W-1:0] r;
    neg = s[SS_W-1];
    m   = neg ? (SS_W'(0) - s) : s;
    r   = (m + S_HALF) >> FRAC_BITS;
    if (neg) return (r > S_MAXP) ? TR_MAX : r[WORD_W-1:0];
    return (r > S_MAXN) ? TR_MIN : WORD_W'(SS_W'(0) - r);
  endfunction

  logic adv;

  // front end: input register, cross products, sign and magnitude
  logic [2:0]                f_v_r;
  logic signed [WORD_W-1:0]  pos0_r [3];
  logic signed [WORD_W-1:0]  dir0_r [3];
  logic signed [WORD_W-1:0]  up0_r  [3];
  logic signed [MAG_W-1:0]   pa1_r  [3];
  logic signed [MAG_W-1:0]   pb1_r  [3];
  logic [WORD_W-1:0]         dmag1_r [3];
  logic [2:0]                dneg1_r;
  logic signed [WORD_W-1:0]  pos1_r [3];
  mag_t [2:0]                cmag2_r;
  logic [2:0]                cneg2_r;
  mag_t [2:0]                dmag2_r;
  logic [2:0]                dneg2_r;
  logic signed [WORD_W-1:0]  pos2_r [3];

  norm_stat_t                stat_a;
  norm_stat_t                stat_b;
  logic [2:0][AW-1:0]        qa;
  logic [2:0][AW-1:0]        qb;
  logic [2*WORD_W-1:0]       side_a;
  logic [WORD_W-1:0]         side_b;

  // tail: v, translations
  logic [T_N-1:0]            t_v_r;
  logic signed [AW-1:0]      uu [3];
  logic signed [AW-1:0]      ww [3];
  logic signed [WORD_W-1:0]  pp [3];
  logic signed [VP_W-1:0]    vpa0_r [3];
  logic signed [VP_W-1:0]    vpb0_r [3];
  logic signed [TP_W-1:0]    tu0_r  [3];
  logic signed [TP_W-1:0]    tw0_r  [3];
  logic signed [AW-1:0]      u0_r [3];
  logic signed [AW-1:0]      w0_r [3];
  logic signed [WORD_W-1:0]  p0_r [3];
  logic                      deg0_r;
  logic [VT_W-1:0]           vt1_r [3];
  logic [SS_W-1:0]           su1_r;
  logic [SS_W-1:0]           sw1_r;
  logic signed [AW-1:0]      u1_r [3];
  logic signed [AW-1:0]      w1_r [3];
  logic signed [WORD_W-1:0]  p1_r [3];
  logic                      deg1_r;
  logic signed [AW-1:0]      v2_r [3];
  logic [WORD_W-1:0]         tru2_r;
  logic [WORD_W-1:0]         trw2_r;
  logic signed [AW-1:0]      u2_r [3];
  logic signed [AW-1:0]      w2_r [3];
  logic signed [WORD_W-1:0]  p2_r [3];
  logic                      deg2_r;
  logic signed [TP_W-1:0]    tv3_r [3];
  logic signed [AW-1:0]      v3_r [3];
  logic signed [AW-1:0]      u3_r [3];
  logic signed [AW-1:0]      w3_r [3];
  logic [WORD_W-1:0]         tru3_r;
  logic [WORD_W-1:0]         trw3_r;
  logic                      deg3_r;
  logic [SS_W-1:0]           sv4_r;
  logic signed [AW-1:0]      v4_r [3];
  logic signed [AW-1:0]      u4_r [3];
  logic signed [AW-1:0]      w4_r [3];
  logic [WORD_W-1:0]         tru4_r;
  logic [WORD_W-1:0]         trw4_r;
  logic                      deg4_r;
  logic signed [AW-1:0]      v5_r [3];
  logic signed [AW-1:0]      u5_r [3];
  logic signed [AW-1:0]      w5_r [3];
  logic [WORD_W-1:0]         tru5_r;
  logic [WORD_W-1:0]         trv5_r;
  logic [WORD_W-1:0]         trw5_r;
  logic                      deg5_r;

  // output hold: one item, three rows
  logic                      hold_v_r;
  row_t                      row_r;
  logic [AXIS_W-1:0]         hold_ax_r [3][3];
  logic [WORD_W-1:0]         hold_tr_r [3];
  logic                      hold_deg_r;

  assign adv      = !hold_v_r || (out_ready && (row_r == ROW_W));
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= '0;
      t_v_r <= '0;
    end else if (adv) begin
      f_v_r <= {f_v_r[1:0], in_valid};
      t_v_r <= {t_v_r[T_N-2:0], stat_a.valid};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [MAG_W:0] df;
    if (adv) begin
      pos0_r <= '{in_pos_x, in_pos_y, in_pos_z};
      dir0_r <= '{in_dir_x, in_dir_y, in_dir_z};
      up0_r  <= '{in_up_x, in_up_y, in_up_z};

      pa1_r[0] <= dir0_r[1] * up0_r[2];
      pb1_r[0] <= dir0_r[2] * up0_r[1];
      pa1_r[1] <= dir0_r[2] * up0_r[0];
      pb1_r[1] <= dir0_r[0] * up0_r[2];
      pa1_r[2] <= dir0_r[0] * up0_r[1];
      pb1_r[2] <= dir0_r[1] * up0_r[0];
      for (int i = 0; i < 3; i++) begin
        dneg1_r[i] <= dir0_r[i][WORD_W-1];
        dmag1_r[i] <= dir0_r[i][WORD_W-1] ? (WORD_W'(0) - dir0_r[i]) : dir0_r[i];
      end
      pos1_r <= pos0_r;

      for (int i = 0; i < 3; i++) begin
        df = (MAG_W+1)'(pa1_r[i]) - (MAG_W+1)'(pb1_r[i]);
        cneg2_r[i] <= df[MAG_W];
        cmag2_r[i] <= df[MAG_W] ? MAG_W'(-df) : df[MAG_W-1:0];
        dmag2_r[i] <= MAG_W'(dmag1_r[i]);
      end
      dneg2_r <= dneg1_r;
      pos2_r  <= pos1_r;
    end
  end

  lav_norm #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (2 * WORD_W)
  ) u_norm_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (f_v_r[2]),
    .in_mag   (cmag2_r),
    .in_neg   (cneg2_r),
    .in_side  ({pos2_r[0], pos2_r[1]}),
    .out_stat (stat_a),
    .out_q    (qa),
    .out_side (side_a)
  );

  lav_norm #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (WORD_W)
  ) u_norm_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (f_v_r[2]),
    .in_mag   (dmag2_r),
    .in_neg   (dneg2_r),
    .in_side  (pos2_r[2]),
    .out_stat (stat_b),
    .out_q    (qb),
    .out_side (side_b)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uu[i] = signed'(qa[i]);
      ww[i] = signed'(qb[i]);
    end
    pp[0] = signed'(side_a[2*WORD_W-1:WORD_W]);
    pp[1] = signed'(side_a[WORD_W-1:0]);
    pp[2] = signed'(side_b);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vpa0_r[0] <= ww[1] * uu[2];
      vpb0_r[0] <= ww[2] * uu[1];
      vpa0_r[1] <= ww[2] * uu[0];
      vpb0_r[1] <= ww[0] * uu[2];
      vpa0_r[2] <= ww[0] * uu[1];
      vpb0_r[2] <= ww[1] * uu[0];
      for (int i = 0; i < 3; i++) begin
        tu0_r[i] <= uu[i] * pp[i];
        tw0_r[i] <= ww[i] * pp[i];
      end
      u0_r   <= uu;
      w0_r   <= ww;
      p0_r   <= pp;
      deg0_r <= stat_a.zero | stat_b.zero;

      for (int i = 0; i < 3; i++) begin
        vt1_r[i] <= VT_W'(vpa0_r[i]) - VT_W'(vpb0_r[i]);
      end
      su1_r  <= SS_W'(tu0_r[0]) + SS_W'(tu0_r[1]) + SS_W'(tu0_r[2]);
      sw1_r  <= SS_W'(tw0_r[0]) + SS_W'(tw0_r[1]) + SS_W'(tw0_r[2]);
      u1_r   <= u0_r;
      w1_r   <= w0_r;
      p1_r   <= p0_r;
      deg1_r <= deg0_r;

      for (int i = 0; i < 3; i++) v2_r[i] <= signed'(round_axis(vt1_r[i]));
      tru2_r <= sat_tr(su1_r);
      trw2_r <= sat_tr(sw1_r);
      u2_r   <= u1_r;
      w2_r   <= w1_r;
      p2_r   <= p1_r;
      deg2_r <= deg1_r;

      for (int i = 0; i < 3; i++) tv3_r[i] <= v2_r[i] * p2_r[i];
      v3_r   <= v2_r;
      u3_r   <= u2_r;
      w3_r   <= w2_r;
      tru3_r <= tru2_r;
      trw3_r <= trw2_r;
      deg3_r <= deg2_r;

      sv4_r  <= SS_W'(tv3_r[0]) + SS_W'(tv3_r[1]) + SS_W'(tv3_r[2]);
      v4_r   <= v3_r;
      u4_r   <= u3_r;
      w4_r   <= w3_r;
      tru4_r <= tru3_r;
      trw4_r <= trw3_r;
      deg4_r <= deg3_r;

      trv5_r <= sat_tr(sv4_r);
      v5_r   <= v4_r;
      u5_r   <= u4_r;
      w5_r   <= w4_r;
      tru5_r <= tru4_r;
      trw5_r <= trw4_r;
      deg5_r <= deg4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      row_r    <= ROW_U;
    end else begin
      if (adv && t_v_r[T_N-1]) begin
        hold_v_r <= 1'b1;
        row_r    <= ROW_U;
      end else if (hold_v_r && out_ready) begin
        if (row_r == ROW_W) begin
          hold_v_r <= 1'b0;
          row_r    <= ROW_U;
        end else begin
          row_r <= row_t'(row_r + 1'b1);
        end
      end
    end
    if (adv && t_v_r[T_N-1]) begin
      for (int i = 0; i < 3; i++) begin
        hold_ax_r[ROW_U][i] <= deg5_r ? '0 : AXIS_W'(u5_r[i]);
        hold_ax_r[ROW_V][i] <= deg5_r ? '0 : AXIS_W'(v5_r[i]);
        hold_ax_r[ROW_W][i] <= deg5_r ? '0 : AXIS_W'(w5_r[i]);
      end
      hold_tr_r[ROW_U] <= deg5_r ? '0 : tru5_r;
      hold_tr_r[ROW_V] <= deg5_r ? '0 : trv5_r;
      hold_tr_r[ROW_W] <= deg5_r ? '0 : trw5_r;
      hold_deg_r       <= deg5_r;
    end
  end

  assign out_valid       = hold_v_r;
  assign out_row_index   = row_r;
  assign out_axis_x      = signed'(hold_ax_r[row_r][0]);
  assign out_axis_y      = signed'(hold_ax_r[row_r][1]);
  assign out_axis_z      = signed'(hold_ax_r[row_r][2]);
  assign out_translation = signed'(hold_tr_r[row_r]);
  assign out_degenerate  = hold_deg_r;
  assign out_last_row    = (row_r == ROW_W);

  // both normalizers run in lockstep
  a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    stat_a.valid == stat_b.valid)
    else $error("normalizer valid bits diverged");

  // an item keeps its rows on the port until the last one is taken
  a_rows_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=> out_valid)
    else $error("item dropped before its last row");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_translation == '0 && out_axis_x == '0)
    else $error("degenerate row not zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && !(out_ready && out_last_row) |-> !in_ready)
    else $error("pipeline advanced while rows pending");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for look_at_view_matrix_core: random and directed items,
// a bit-exact look-at basis predictor and row-by-row comparison of every result item
// depends on lav_pkg and look_at_view_matrix_core
`timescale 1ns / 1ps

module testbench;
  import lav_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RAND = 350;

  typedef struct packed {
    logic signed [31:0] px, py, pz, dx, dy, dz, ux, uy, uz;
  } view_in_t;

  typedef struct packed {
    logic [1:0] row;
    logic signed [17:0] ax, ay, az;
    logic signed [31:0] tr;
    logic degen;
    logic last;
  } view_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_row_index;
  logic signed [17:0] out_axis_x, out_axis_y, out_axis_z;
  logic signed [31:0] out_translation;
  logic out_degenerate, out_last_row;

  view_in_t pending_items[$];
  view_row_t expected_rows[$];
  int errors = 0;
  int in_idle_pct = 22;
  int out_idle_pct = 75;
  bit hold_send = 1'b0;
  bit all_queued = 1'b0;

  always #6 clk = ~clk;

  look_at_view_matrix_core u_top (.*);

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(logic [63:0] mag[3], bit neg[3],
                                  output longint q[3]);
    logic [63:0] m[3], mx, sum, len, r;
    int sh;
    mx = 0; sum = 0; sh = 0;
    for (int i = 0; i < 3; i++) if (mag[i] > mx) mx = mag[i];
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 31)) begin mx >>= 1; sh--; end
    while (mx < (64'd1 << 30)) begin mx <<= 1; sh++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = sh >= 0 ? mag[i] << sh : mag[i] >> (-sh);
      sum += m[i] * m[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      r = ((m[i] << FB) + len / 2) / len;
      if (r > (64'd1 << FB)) r = 64'd1 << FB;
      q[i] = neg[i] ? -longint'(r) : longint'(r);
    end
    return 1'b1;
  endfunction

  function automatic longint round_down(longint t);
    logic [63:0] m;
    m = t < 0 ? -t : t;
    m = (m + (64'd1 << (FB - 1))) >> FB;
    return t < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void predict_rows(view_in_t it);
    longint pos[3], d[3], up[3], ax[3][3], p, r, t, s, tr;
    logic [63:0] mag[3];
    bit neg[3];
    bit ok;
    longint q[3];
    view_row_t row;
    pos = '{it.px, it.py, it.pz};
    d = '{it.dx, it.dy, it.dz};
    up = '{it.ux, it.uy, it.uz};
    for (int i = 0; i < 3; i++) begin
      p = d[(i+1)%3] * up[(i+2)%3];
      r = d[(i+2)%3] * up[(i+1)%3];
      neg[i] = p < r;
      mag[i] = p >= r ? p - r : r - p;
    end
    ok = unit_vec(mag, neg, q);
    ax[0] = q;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] = d[i] < 0;
        mag[i] = d[i] < 0 ? -d[i] : d[i];
      end
      ok = unit_vec(mag, neg, q);
      ax[2] = q;
    end
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        t = ax[2][(i+1)%3] * ax[0][(i+2)%3] - ax[2][(i+2)%3] * ax[0][(i+1)%3];
        r = round_down(t);
        if (r > (64'sd1 <<< FB)) r = 64'sd1 <<< FB;
        if (r < -(64'sd1 <<< FB)) r = -(64'sd1 <<< FB);
        ax[1][i] = r;
      end
    end
    for (int k = 0; k < 3; k++) begin
      tr = 0;
      if (ok) begin
        s = ax[k][0] * pos[0] + ax[k][1] * pos[1] + ax[k][2] * pos[2];
        tr = round_down(-s);
        if (tr > 64'sh7FFFFFFF) tr = 64'sh7FFFFFFF;
        if (tr < -64'sh80000000) tr = -64'sh80000000;
      end
      row.row = k[1:0];
      row.ax = ok ? ax[k][0][17:0] : '0;
      row.ay = ok ? ax[k][1][17:0] : '0;
      row.az = ok ? ax[k][2][17:0] : '0;
      row.tr = tr[31:0];
      row.degen = !ok;
      row.last = (k == 2);
      expected_rows.push_back(row);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_rows(pending_items.pop_front());
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && !hold_send &&
          $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        {in_pos_x, in_pos_y, in_pos_z, in_dir_x, in_dir_y, in_dir_z,
         in_up_x, in_up_y, in_up_z} <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    view_row_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_row_index, out_axis_x, out_axis_y, out_axis_z, out_translation,
              out_degenerate, out_last_row};
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row item %p", got);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom_range(131072) - 65536;
      4: return $urandom_range(2097152) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic view_in_t rand_item();
    view_in_t it;
    logic signed [31:0] k;
    it = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
          rand_word(), rand_word(), rand_word(), rand_word()};
    case ($urandom_range(9))
      0: begin
        k = $urandom_range(7) - 3;
        it.ux = it.dx * k; it.uy = it.dy * k; it.uz = it.dz * k;
      end
      1: {it.dx, it.dy, it.dz} = '0;
      2: {it.ux, it.uy, it.uz} = '0;
      default: ;
    endcase
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0)
      @(posedge clk);
  endtask

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MN = 32'sh8000_0000;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    pending_items.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -ONE, 32'sd0, ONE, 32'sd0});
    pending_items.push_back({ONE, 2*ONE, 3*ONE, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE});
    pending_items.push_back({MX, MX, MX, MX, MX, MX, MN, MX, 32'sd0});
    pending_items.push_back({MN, MN, MN, MN, MN, MN, MX, MN, MX});
    pending_items.push_back({MX, MN, MX, MN, 32'sd1, MX, 32'sd1, 32'sd0, MN});
    pending_items.push_back({MX, MX, MX, 32'sd0, 32'sd0, 32'sd0, ONE, ONE, ONE});
    pending_items.push_back({ONE, ONE, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE});
    pending_items.push_back({ONE, ONE, ONE, ONE, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0});
    pending_items.push_back({-ONE, MX, ONE, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0});
    pending_items.push_back({MN, MX, 32'sd0, MX, 32'sd0, 32'sd0, 32'sd0, MX, 32'sd0});
    pending_items.push_back({MX, MX, MX, -1, -1, -1, MN, MX, -1});
    pending_items.push_back({32'sd0, MX, MN, 32'sd3, 32'sd4, 32'sd0, 32'sd0, 32'sd0, 32'sd1});
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = ph == 0 ? 22 : ph == 1 ? 75 : 0;
      out_idle_pct = ph == 0 ? 75 : ph == 1 ? 22 : 0;
      for (int i = 0; i < N_RAND / 3; i++) begin
        if (ph == 1 && i == 40) begin
          while (pending_items.size() > 20) @(posedge clk);
          hold_send = 1'b1;
          while (in_valid || expected_rows.size() != 0) @(posedge clk);
          hold_send = 1'b0;
        end
        pending_items.push_back(rand_item());
      end
      wait_drained();
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ look_at_view_matrix_core.f @@
design/lav_pkg.sv
design/lav_norm.sv
design/look_at_view_matrix_core.sv
tb/sv/testbench.sv
